>>> design/alu8_pkg.sv
// Package for the 8-bit ALU: opcodes, transfer payload types, pipeline types and divider step.
`timescale 1ns / 1ps

package alu8_pkg;

  // Opcodes.
  localparam logic [4:0] OP_MOV  = 5'd0;
  localparam logic [4:0] OP_AND  = 5'd1;
  localparam logic [4:0] OP_OR   = 5'd2;
  localparam logic [4:0] OP_XOR  = 5'd3;
  localparam logic [4:0] OP_NOT  = 5'd4;
  localparam logic [4:0] OP_NAND = 5'd5;
  localparam logic [4:0] OP_NOR  = 5'd6;
  localparam logic [4:0] OP_XNOR = 5'd7;
  localparam logic [4:0] OP_SHL  = 5'd8;
  localparam logic [4:0] OP_SHR  = 5'd9;
  localparam logic [4:0] OP_ADD  = 5'd10;
  localparam logic [4:0] OP_SADD = 5'd11;
  localparam logic [4:0] OP_SUB  = 5'd12;
  localparam logic [4:0] OP_SSUB = 5'd13;
  localparam logic [4:0] OP_MUL  = 5'd14;
  localparam logic [4:0] OP_SMUL = 5'd15;
  localparam logic [4:0] OP_DIV  = 5'd16;
  localparam logic [4:0] OP_SDIV = 5'd17;
  localparam logic [4:0] OP_MOD  = 5'd18;
  localparam logic [4:0] OP_SMOD = 5'd19;
  localparam logic [4:0] OP_INC  = 5'd20;
  localparam logic [4:0] OP_DEC  = 5'd21;
  localparam logic [4:0] OP_CMP  = 5'd22;

  // Byte constants.
  localparam logic [7:0] SIGN_BIT = 8'h80;
  localparam logic [7:0] NEXT_BIT = 8'h40;
  localparam logic [7:0] LOW_BIT  = 8'h01;

  // Internal stages ahead of the output register; stages 1 to 4 each retire two divider bits.
  localparam int NUM_STAGES    = 5;
  localparam int DIV_PER_STAGE = 2;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    logic       carry_flag;
    logic       zero_flag;
    logic       sign_flag;
    logic       overflow_flag;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r;
    logic        cf;
    logic        ovf;
    logic [15:0] prod;
    logic [7:0]  rem;
    logic [7:0]  quo;
    logic [7:0]  dvs;
    logic        neg_q;
    logic        neg_r;
    logic        dz;
    logic        sovf;
  } pipe_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] quo;
  } div_state_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(input logic [7:0] rem, input logic [7:0] quo,
                                          input logic [7:0] dvs);
    logic [8:0] t;
    logic [8:0] d;
    div_state_t s;
    t = {rem, quo[7]};
    d = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      s.rem = d[7:0];
      s.quo = {quo[6:0], 1'b1};
    end else begin
      s.rem = t[7:0];
      s.quo = {quo[6:0], 1'b0};
    end
    return s;
  endfunction

endpackage

>>> design/alu8_with_flags.sv
// Top level of the pipelined 8-bit ALU with carry, zero, sign and overflow flags.
// Each result passes through stage registers 0 to 4 and the output register to out_valid.
// Throughput: one operation per cycle; a stall holds each full stage whose successor is
// full, while empty stages ahead of it keep filling.
// The depth is set by the 8-step divider, which retires two quotient bits per stage.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module alu8_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alu8_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output alu8_pkg::out_item_t out_data
);

  localparam int NS = alu8_pkg::NUM_STAGES;

  // Stage registers. Stage 0 holds the decoded operation, the simple results, the
  // raw product and the divider setup. Stages 1 to 4 run the divider; stage 1 also
  // finishes the multiply flags. The output register forms the final flags.
  alu8_pkg::pipe_t     stage_r   [0:NS-1];
  alu8_pkg::pipe_t     stage0_nxt;
  alu8_pkg::pipe_t     stage_nxt [1:NS-1];
  logic [NS-1:0]       valid_r;
  logic [NS:0]         ready;
  alu8_pkg::out_item_t out_r;
  alu8_pkg::out_item_t out_nxt;
  logic                out_valid_r;

  // Backward ready chain: a stage may load when it is empty or its successor loads.
  always_comb begin
    ready[NS] = !out_valid_r || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stage 0: decode and the simple operations.
  always_comb begin
    alu8_pkg::pipe_t p;
    logic [8:0] sum;
    logic [8:0] diff;
    logic       sgn;
    logic [7:0] a;
    logic [7:0] b;
    a       = in_data.operand_a;
    b       = in_data.operand_b;
    sum     = {1'b0, a} + {1'b0, b};
    diff    = {1'b0, a} - {1'b0, b};
    p       = '0;
    p.cmd   = in_data.cmd;
    p.a     = a;
    p.b     = b;
    p.prod  = 16'(a) * 16'(b);
    case (in_data.cmd)
      alu8_pkg::OP_MOV:  p.r = b;
      alu8_pkg::OP_AND:  p.r = a & b;
      alu8_pkg::OP_OR:   p.r = a | b;
      alu8_pkg::OP_XOR:  p.r = a ^ b;
      alu8_pkg::OP_NOT:  p.r = ~a;
      alu8_pkg::OP_NAND: p.r = ~(a & b);
      alu8_pkg::OP_NOR:  p.r = ~(a | b);
      alu8_pkg::OP_XNOR: p.r = ~(a ^ b);
      alu8_pkg::OP_SHL: begin
        p.r   = {a[6:0], 1'b0};
        p.cf  = |(a & alu8_pkg::SIGN_BIT);
        p.ovf = a[6] & a[5];
      end
      alu8_pkg::OP_SHR: begin
        // The top bit of the result is always clear, so overflow stays 0.
        p.r  = {1'b0, a[7:1]};
        p.cf = |(a & alu8_pkg::LOW_BIT);
      end
      alu8_pkg::OP_ADD, alu8_pkg::OP_SADD: begin
        p.r   = sum[7:0];
        p.cf  = sum[8];
        p.ovf = |((a ^ sum[7:0]) & (b ^ sum[7:0]) & alu8_pkg::SIGN_BIT);
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SSUB, alu8_pkg::OP_CMP: begin
        p.r   = diff[7:0];
        p.cf  = diff[8];
        p.ovf = |((a ^ b) & (a ^ diff[7:0]) & alu8_pkg::SIGN_BIT);
      end
      alu8_pkg::OP_INC: begin
        p.r   = a + 8'd1;
        p.cf  = (a == 8'hFF);
        p.ovf = (a == 8'h7F);
      end
      alu8_pkg::OP_DEC: begin
        p.r   = a - 8'd1;
        p.cf  = (a == 8'h00);
        p.ovf = (a == alu8_pkg::SIGN_BIT);
      end
      default: p.r = '0;
    endcase
    // Divider setup: magnitudes of the operands and the signs to restore later.
    sgn     = (in_data.cmd == alu8_pkg::OP_SDIV) || (in_data.cmd == alu8_pkg::OP_SMOD);
    p.quo   = (sgn && a[7]) ? (8'd0 - a) : a;
    p.dvs   = (sgn && b[7]) ? (8'd0 - b) : b;
    p.rem   = '0;
    p.neg_q = sgn && (a[7] ^ b[7]);
    p.neg_r = sgn && a[7];
    p.dz    = (b == 8'h00);
    p.sovf  = (in_data.cmd == alu8_pkg::OP_SDIV) && (a == alu8_pkg::SIGN_BIT) && (b == 8'hFF);
    stage0_nxt = p;
  end

  // Stages 1 to 4: two divider steps each; stage 1 also settles the multiply.
  always_comb begin
    alu8_pkg::pipe_t    t;
    alu8_pkg::div_state_t s;
    logic [15:0]        sp;
    for (int k = 1; k < NS; k++) begin
      t = stage_r[k-1];
      for (int j = 0; j < alu8_pkg::DIV_PER_STAGE; j++) begin
        s     = alu8_pkg::div_step(t.rem, t.quo, t.dvs);
        t.rem = s.rem;
        t.quo = s.quo;
      end
      if (k == 1) begin
        // Signed product from the unsigned one: subtract the weight of each sign bit.
        sp = t.prod - (t.a[7] ? {t.b, 8'h00} : 16'h0000)
                    - (t.b[7] ? {t.a, 8'h00} : 16'h0000);
        if (t.cmd == alu8_pkg::OP_MUL) begin
          t.r   = t.prod[7:0];
          t.cf  = |t.prod[15:8];
          t.ovf = |t.prod[15:7];
        end else if (t.cmd == alu8_pkg::OP_SMUL) begin
          t.r   = t.prod[7:0];
          t.cf  = |t.prod[15:8];
          t.ovf = !((sp[15:7] == 9'h000) || (sp[15:7] == 9'h1FF));
        end
      end
      stage_nxt[k] = t;
    end
  end

  // Output stage: restore signs of quotient and remainder, form the flags.
  always_comb begin
    alu8_pkg::pipe_t t;
    logic [7:0]      q;
    logic [7:0]      rm;
    logic            is_div;
    logic            known;
    logic [7:0]      r;
    logic            cf;
    logic            ovf;
    t      = stage_r[NS-1];
    q      = t.neg_q ? (8'd0 - t.quo) : t.quo;
    rm     = t.neg_r ? (8'd0 - t.rem) : t.rem;
    is_div = t.cmd inside {alu8_pkg::OP_DIV, alu8_pkg::OP_SDIV,
                           alu8_pkg::OP_MOD, alu8_pkg::OP_SMOD};
    known  = (t.cmd <= alu8_pkg::OP_CMP);
    r      = t.r;
    cf     = t.cf;
    ovf    = t.ovf;
    if (is_div) begin
      r   = (t.cmd inside {alu8_pkg::OP_DIV, alu8_pkg::OP_SDIV}) ? q : rm;
      cf  = 1'b0;
      ovf = t.sovf;
    end
    if (is_div && t.dz) begin
      // Division by zero: nothing is written, carry and overflow mark the fault.
      out_nxt = '{result: 8'h00, write_back: 1'b0, carry_flag: 1'b1, zero_flag: 1'b0,
                  sign_flag: 1'b0, overflow_flag: 1'b1};
    end else if (!known) begin
      // Undefined opcodes give an all-zero transfer.
      out_nxt = '0;
    end else begin
      out_nxt.result        = r;
      out_nxt.write_back    = (t.cmd != alu8_pkg::OP_CMP);
      out_nxt.carry_flag    = cf;
      out_nxt.zero_flag     = (r == 8'h00);
      out_nxt.sign_flag     = |(r & alu8_pkg::SIGN_BIT);
      out_nxt.overflow_flag = ovf;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ready[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
      if (ready[NS]) begin
        out_valid_r <= valid_r[NS-1];
      end
    end
  end

  // Payload registers load only when a valid item moves in.
  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      stage_r[0] <= stage0_nxt;
    end
    for (int k = 1; k < NS; k++) begin
      if (ready[k] && valid_r[k-1]) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
    if (ready[NS] && valid_r[NS-1]) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> test/tb_alu8_with_flags.sv
// Self-checking testbench for the 8-bit ALU with status flags: directed vectors, then random traffic.
`timescale 1ns / 1ps

module tb_alu8_with_flags;

  // Opcodes 23 through 31 are not decoded by the ALU and must give an all-zero result.
  localparam logic [4:0] OP_FIRST_UNDEFINED = 5'd23;
  localparam logic [4:0] OP_LAST_UNDEFINED  = 5'd31;

  localparam int RANDOM_OPS    = 500;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_DIRECTED  = 26;

  // One row of the directed table. When has_golden is set, the expected result byte and
  // the flags (write_back, carry, zero, sign, overflow, in that order) are typed in below.
  // Otherwise the expected result comes from the flag predictor.
  typedef struct packed {
    alu8_pkg::in_item_t stim;
    logic               has_golden;
    logic [7:0]         golden_result;
    logic [4:0]         golden_flags;
  } vector_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  alu8_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  alu8_pkg::out_item_t out_data;

  // The expectation that travels with the operation currently offered on the input side.
  // It is updated with the same nonblocking timing as in_data, so the monitor always sees
  // the value that belongs to the operation accepted at that clock edge.
  alu8_pkg::out_item_t offered_expect = '0;

  alu8_pkg::out_item_t expected_results[$];
  int unsigned failures        = 0;
  int unsigned ops_sent        = 0;
  int unsigned results_checked = 0;
  int unsigned div_zero_ops    = 0;
  int unsigned undefined_ops   = 0;
  int unsigned cycle_count     = 0;

  vector_row_t directed_vectors [0:NUM_DIRECTED-1] = '{
    {alu8_pkg::OP_MOV,  8'h00, 8'hFF, 1'b1, 8'hFF, 5'b10010},
    {alu8_pkg::OP_MOV,  8'hFF, 8'h00, 1'b1, 8'h00, 5'b10100},
    {alu8_pkg::OP_AND,  8'hF0, 8'h3C, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_XOR,  8'hA5, 8'h5A, 1'b1, 8'hFF, 5'b10010},
    {alu8_pkg::OP_NOT,  8'h00, 8'h55, 1'b1, 8'hFF, 5'b10010},
    {alu8_pkg::OP_NAND, 8'hFF, 8'hFF, 1'b1, 8'h00, 5'b10100},
    {alu8_pkg::OP_NOR,  8'h0F, 8'h30, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_XNOR, 8'h96, 8'h69, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_SHL,  8'h80, 8'h00, 1'b1, 8'h00, 5'b11100},
    {alu8_pkg::OP_SHL,  8'h60, 8'hFF, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_SHR,  8'h01, 8'h00, 1'b1, 8'h00, 5'b11100},
    {alu8_pkg::OP_ADD,  8'hFF, 8'h01, 1'b1, 8'h00, 5'b11100},
    {alu8_pkg::OP_SADD, 8'h7F, 8'h01, 1'b1, 8'h80, 5'b10011},
    {alu8_pkg::OP_SUB,  8'h00, 8'h01, 1'b1, 8'hFF, 5'b11010},
    {alu8_pkg::OP_SSUB, 8'h80, 8'h01, 1'b1, 8'h7F, 5'b10001},
    {alu8_pkg::OP_MUL,  8'hFF, 8'hFF, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_SMUL, 8'h80, 8'hFF, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_DIV,  8'h12, 8'h00, 1'b1, 8'h00, 5'b01001},
    {alu8_pkg::OP_SDIV, 8'h80, 8'hFF, 1'b1, 8'h80, 5'b10011},
    {alu8_pkg::OP_SMOD, 8'h80, 8'hFF, 1'b1, 8'h00, 5'b10100},
    {alu8_pkg::OP_MOD,  8'hFF, 8'h07, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_SMOD, 8'hF9, 8'h03, 1'b0, 8'h00, 5'b00000},
    {alu8_pkg::OP_INC,  8'hFF, 8'h00, 1'b1, 8'h00, 5'b11100},
    {alu8_pkg::OP_DEC,  8'h80, 8'h00, 1'b1, 8'h7F, 5'b10001},
    {alu8_pkg::OP_CMP,  8'h05, 8'h05, 1'b1, 8'h00, 5'b00100},
    {OP_LAST_UNDEFINED, 8'hFF, 8'hFF, 1'b1, 8'h00, 5'b00000}
  };

  alu8_with_flags u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Computes the result byte and flags that the ALU must give for one operation.
  function automatic alu8_pkg::out_item_t predict_alu_flags(input alu8_pkg::in_item_t op);
    logic [7:0]          a;
    logic [7:0]          b;
    logic [7:0]          r;
    logic [8:0]          sum;
    logic [15:0]         uprod;
    logic                cf;
    logic                ovf;
    logic                wb;
    int                  sa;
    int                  sb;
    int                  sres;
    alu8_pkg::out_item_t res;
    a     = op.operand_a;
    b     = op.operand_b;
    sa    = $signed(a);
    sb    = $signed(b);
    uprod = a * b;
    r     = '0;
    cf    = 1'b0;
    ovf   = 1'b0;
    wb    = 1'b1;
    res   = '0;
    case (op.cmd)
      alu8_pkg::OP_MOV:  r = b;
      alu8_pkg::OP_AND:  r = a & b;
      alu8_pkg::OP_OR:   r = a | b;
      alu8_pkg::OP_XOR:  r = a ^ b;
      alu8_pkg::OP_NOT:  r = ~a;
      alu8_pkg::OP_NAND: r = ~(a & b);
      alu8_pkg::OP_NOR:  r = ~(a | b);
      alu8_pkg::OP_XNOR: r = ~(a ^ b);
      alu8_pkg::OP_SHL: begin
        r   = {a[6:0], 1'b0};
        cf  = a[7];
        ovf = r[7] & r[6];
      end
      alu8_pkg::OP_SHR: begin
        r   = {1'b0, a[7:1]};
        cf  = a[0];
        ovf = r[7] & r[6];
      end
      alu8_pkg::OP_ADD, alu8_pkg::OP_SADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r   = sum[7:0];
        cf  = sum[8];
        ovf = (a[7] == b[7]) && (r[7] != a[7]);
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SSUB, alu8_pkg::OP_CMP: begin
        r   = a - b;
        cf  = a < b;
        ovf = (a[7] != b[7]) && (r[7] != a[7]);
        wb  = (op.cmd != alu8_pkg::OP_CMP);
      end
      alu8_pkg::OP_MUL: begin
        r   = uprod[7:0];
        cf  = uprod > 16'd255;
        ovf = uprod > 16'd127;
      end
      alu8_pkg::OP_SMUL: begin
        sres = sa * sb;
        r    = sres[7:0];
        cf   = uprod > 16'd255;
        ovf  = (sres > 127) || (sres < -128);
      end
      alu8_pkg::OP_DIV, alu8_pkg::OP_SDIV, alu8_pkg::OP_MOD, alu8_pkg::OP_SMOD: begin
        if (b == 8'h00) begin
          // Division by zero writes nothing and raises carry and overflow only.
          res.carry_flag    = 1'b1;
          res.overflow_flag = 1'b1;
          return res;
        end
        case (op.cmd)
          alu8_pkg::OP_DIV: r = a / b;
          alu8_pkg::OP_MOD: r = a % b;
          alu8_pkg::OP_SDIV: begin
            sres = sa / sb;
            r    = sres[7:0];
            ovf  = (sa == -128) && (sb == -1);
          end
          default: begin
            sres = sa % sb;
            r    = sres[7:0];
          end
        endcase
      end
      alu8_pkg::OP_INC: begin
        r   = a + 8'd1;
        cf  = (a == 8'hFF);
        ovf = (a == 8'h7F);
      end
      alu8_pkg::OP_DEC: begin
        r   = a - 8'd1;
        cf  = (a == 8'h00);
        ovf = (a == 8'h80);
      end
      default: return res;
    endcase
    res.result        = r;
    res.write_back    = wb;
    res.carry_flag    = cf;
    res.zero_flag     = (r == 8'h00);
    res.sign_flag     = r[7];
    res.overflow_flag = ovf;
    return res;
  endfunction

  // Operand bytes lean toward the values where carries, borrows and overflows happen.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'hFF;
      5:       return 8'hFE;
      6:       return 8'h81;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic alu8_pkg::in_item_t random_alu_op();
    alu8_pkg::in_item_t op;
    if ($urandom_range(0, 99) < 5) begin
      op.cmd = 5'($urandom_range(OP_FIRST_UNDEFINED, OP_LAST_UNDEFINED));
    end else begin
      op.cmd = 5'($urandom_range(alu8_pkg::OP_MOV, alu8_pkg::OP_CMP));
    end
    op.operand_a = pick_operand();
    op.operand_b = pick_operand();
    // Give the divider a fair share of zero divisors.
    if (op.cmd >= alu8_pkg::OP_DIV && op.cmd <= alu8_pkg::OP_SMOD &&
        $urandom_range(0, 9) == 0) begin
      op.operand_b = 8'h00;
    end
    return op;
  endfunction

  // Offers one operation and returns at the clock edge where the transfer happens.
  // in_valid stays high on return, so a following call keeps the burst going with a
  // single nonblocking write per signal in that time step.
  task automatic send_alu_op(input alu8_pkg::in_item_t op,
                             input alu8_pkg::out_item_t expect_res);
    in_valid       <= 1'b1;
    in_data        <= op;
    offered_expect <= expect_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_sent++;
    if (op.cmd >= alu8_pkg::OP_DIV && op.cmd <= alu8_pkg::OP_SMOD &&
        op.operand_b == 8'h00) div_zero_ops++;
    if (op.cmd >= OP_FIRST_UNDEFINED) undefined_ops++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The receiver picks a new stall behavior whenever the low six bits of stall_cycle are zero:
  // no stalls at all, random stalls, or a fixed pattern set by the low four bits of stall_cycle.
  logic [31:0] stall_cycle = '0;
  logic [1:0]  stall_mode  = '0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 32'd1;
    if (stall_cycle[5:0] == 6'd0) begin
      stall_mode <= 2'($urandom_range(0, 2));
    end
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 99) < 35);
      default: out_stall <= (stall_cycle[3:0] < 4'd9);
    endcase
  end

  // Scoreboard. Each result transfer is checked against the oldest outstanding
  // expectation; each input transfer queues the expectation that came with it.
  always @(posedge clk) begin : scoreboard
    alu8_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("Result %h arrived with no operation outstanding", out_data);
          end
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_data !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("Mismatch on result %0d: expected res=%h wb=%b c=%b z=%b s=%b v=%b",
                       results_checked, want.result, want.write_back, want.carry_flag,
                       want.zero_flag, want.sign_flag, want.overflow_flag);
              $display("                        actual   res=%h wb=%b c=%b z=%b s=%b v=%b",
                       out_data.result, out_data.write_back, out_data.carry_flag,
                       out_data.zero_flag, out_data.sign_flag, out_data.overflow_flag);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(offered_expect);
      end
    end
  end

  // Watchdog. The slowest legal run is far below this limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    alu8_pkg::in_item_t  op;
    alu8_pkg::out_item_t golden;
    int unsigned         burst_left;
    burst_left = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed vectors run back to back, so the pipeline is full while they pass.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      op = directed_vectors[i].stim;
      if (directed_vectors[i].has_golden) begin
        golden = {directed_vectors[i].golden_result, directed_vectors[i].golden_flags};
      end else begin
        golden = predict_alu_flags(op);
      end
      send_alu_op(op, golden);
    end
    wait_for_drain();

    // Random traffic in bursts of random length separated by random gaps. Half way
    // through, the sender stops until every outstanding result has come back.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 2) begin
        wait_for_drain();
      end
      if (burst_left == 0) begin
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end
      op = random_alu_op();
      send_alu_op(op, predict_alu_flags(op));
      burst_left--;
    end

    wait_for_drain();
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      failures += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d operations (%0d directed, %0d divide by zero, %0d undefined opcodes),",
             ops_sent, NUM_DIRECTED, div_zero_ops, undefined_ops);
    $display("checked %0d results under random sender gaps and receiver stalls; %0d failures.",
             results_checked, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/alu8_pkg.sv
design/alu8_with_flags.sv
test/tb_alu8_with_flags.sv
